// ----- src/bomap_pkg.sv -----
// shared types, constants and codes of the block owner map allocator
`default_nettype none
package bomap_pkg;

    // default sizes of the owner map
    localparam int NUM_BLOCKS_DEF = 1024;
    localparam int NUM_FILES_DEF  = 64;

    // field widths
    localparam int OP_W  = 2;
    localparam int FID_W = 6;
    localparam int BN_W  = 10;
    localparam int BI_W  = 10;
    localparam int DS_W  = 10;
    localparam int TAG_W = 7;

    // owner tag of a free block
    localparam logic [TAG_W-1:0] FREE_TAG = 7'd127;

    // operation codes
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

    // result status codes
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_DATA_START = 1'b0;

    // input word
    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [FID_W-1:0] file_id;
        logic [BN_W-1:0]  blk_ord;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [BI_W-1:0] blk_idx;
        logic            status;
    } t_out_word;

    // sequencer states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// ----- src/block_owner_map_allocator.sv -----
// top level of the block owner map allocator
`default_nettype none
// Keeps a 7-bit owner tag per disk block in a single-port-write, single-port-read
// memory and serves one word at a time: allocate, lookup n-th owned block, or
// release all blocks of a file. Each word scans the map from data_start upward,
// one entry per cycle, and stops early when allocate or lookup hits; words that
// need no scan (bad opcode, file id or data_start) go straight to the result.
// After reset the block runs a clearing pass that marks every block free, and
// accepts no word until it is done; configuration writes are taken at any time.
// The result sits in an output register, so the next word may be accepted while
// it waits.
module block_owner_map_allocator #(
    parameter int NUM_BLOCKS = bomap_pkg::NUM_BLOCKS_DEF,
    parameter int NUM_FILES  = bomap_pkg::NUM_FILES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bomap_pkg::APB_AW-1:0] paddr,
    input  wire logic [bomap_pkg::APB_DW-1:0] pwdata,
    output logic      [bomap_pkg::APB_DW-1:0] prdata,
    output logic                              pready,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire bomap_pkg::t_in_word          i_in_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output bomap_pkg::t_out_word              o_out_data
);

    localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    logic [bomap_pkg::DS_W-1:0]  data_start;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [bomap_pkg::TAG_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [AW-1:0]               mem_raddr;
    logic [bomap_pkg::TAG_W-1:0] mem_rdata;

    // configuration register
    bomap_apb u_apb (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_data_start (data_start)
    );

    // scan sequencer
    bomap_scan #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .NUM_FILES  (NUM_FILES),
        .AW         (AW)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_data_start (data_start),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_re     (mem_re),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

    // owner map
    bomap_mem #(
        .DEPTH (NUM_BLOCKS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule
`default_nettype wire

// ----- src/bomap_mem.sv -----
// owner map storage: one write port, one read port, registered read data
`default_nettype none
module bomap_mem #(
    parameter int DEPTH = bomap_pkg::NUM_BLOCKS_DEF,
    parameter int AW    = $clog2(bomap_pkg::NUM_BLOCKS_DEF)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [AW-1:0]               i_waddr,
    input  wire logic [bomap_pkg::TAG_W-1:0] i_wdata,
    input  wire logic                        i_re,
    input  wire logic [AW-1:0]               i_raddr,
    output logic      [bomap_pkg::TAG_W-1:0] o_rdata
);

    logic [bomap_pkg::TAG_W-1:0] r_mem [DEPTH];
    logic [bomap_pkg::TAG_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- src/bomap_apb.sv -----
// configuration register file behind the apb port
`default_nettype none
module bomap_apb (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bomap_pkg::APB_AW-1:0] paddr,
    input  wire logic [bomap_pkg::APB_DW-1:0] pwdata,
    output logic      [bomap_pkg::APB_DW-1:0] prdata,
    output logic                              pready,
    output logic      [bomap_pkg::DS_W-1:0]   o_data_start
);

    logic                         reg_sel;
    logic                         wr_en;
    logic [bomap_pkg::DS_W-1:0]   r_data_start;
    logic [bomap_pkg::DS_W-1:0]   n_data_start;

    // register decode, one word per register
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        n_data_start = r_data_start;
        if (wr_en && (reg_sel == bomap_pkg::REG_DATA_START)) begin
            n_data_start = pwdata[bomap_pkg::DS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_start <= '0;
        end else begin
            r_data_start <= n_data_start;
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        if (reg_sel == bomap_pkg::REG_DATA_START) begin
            prdata = bomap_pkg::APB_DW'(r_data_start);
        end
    end

    assign pready       = 1'b1;
    assign o_data_start = r_data_start;

endmodule
`default_nettype wire

// ----- src/bomap_scan.sv -----
// scan sequencer: clearing pass, read-modify-write scan and result register
`default_nettype none
module bomap_scan #(
    parameter int NUM_BLOCKS = bomap_pkg::NUM_BLOCKS_DEF,
    parameter int NUM_FILES  = bomap_pkg::NUM_FILES_DEF,
    parameter int AW         = $clog2(NUM_BLOCKS)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [bomap_pkg::DS_W-1:0]  i_data_start,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire bomap_pkg::t_in_word         i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output bomap_pkg::t_out_word             o_out_data,
    output logic                             o_mem_we,
    output logic      [AW-1:0]               o_mem_waddr,
    output logic      [bomap_pkg::TAG_W-1:0] o_mem_wdata,
    output logic                             o_mem_re,
    output logic      [AW-1:0]               o_mem_raddr,
    input  wire logic [bomap_pkg::TAG_W-1:0] i_mem_rdata
);

    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam logic [CNT_W-1:0] ADDR_END  = CNT_W'(NUM_BLOCKS);
    localparam logic [CNT_W-1:0] ADDR_LAST = CNT_W'(NUM_BLOCKS - 1);

    bomap_pkg::t_state              r_state, n_state;
    logic [CNT_W-1:0]               r_addr, n_addr;
    logic                           r_rd_valid, n_rd_valid;
    logic [AW-1:0]                  r_rd_addr, n_rd_addr;
    logic [bomap_pkg::OP_W-1:0]     r_op, n_op;
    logic [bomap_pkg::FID_W-1:0]    r_fid, n_fid;
    logic [bomap_pkg::BN_W-1:0]     r_want, n_want;
    logic [bomap_pkg::BN_W-1:0]     r_count, n_count;
    bomap_pkg::t_out_word           r_res, n_res;
    logic                           r_out_valid, n_out_valid;
    bomap_pkg::t_out_word           r_out, n_out;

    logic                           op_legal;
    logic                           fid_ok;
    logic                           start_ok;
    logic [bomap_pkg::TAG_W-1:0]    fid_tag;

    // checks on the incoming word
    assign op_legal = (i_in_data.opcode == bomap_pkg::OP_ALLOC)
                   || (i_in_data.opcode == bomap_pkg::OP_LOOKUP)
                   || (i_in_data.opcode == bomap_pkg::OP_RELEASE);
    assign fid_ok   = 32'(i_in_data.file_id) < 32'(NUM_FILES);
    assign start_ok = 32'(i_data_start) < 32'(NUM_BLOCKS);
    assign fid_tag  = bomap_pkg::TAG_W'(r_fid);

    // next state and memory control
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_rd_valid  = r_rd_valid;
        n_rd_addr   = r_rd_addr;
        n_op        = r_op;
        n_fid       = r_fid;
        n_want      = r_want;
        n_count     = r_count;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_in_ready  = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_rd_addr;
        o_mem_wdata = bomap_pkg::FREE_TAG;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_addr[AW-1:0];

        // result taken downstream
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            // mark every block free after reset
            bomap_pkg::S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_addr[AW-1:0];
                n_addr      = r_addr + 1'b1;
                if (r_addr == ADDR_LAST) begin
                    n_addr  = '0;
                    n_state = bomap_pkg::S_IDLE;
                end
            end

            // take a word and decide whether a scan is needed
            bomap_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op       = i_in_data.opcode;
                    n_fid      = i_in_data.file_id;
                    n_want     = i_in_data.blk_ord;
                    n_count    = '0;
                    n_rd_valid = 1'b0;
                    if (op_legal && fid_ok && start_ok) begin
                        n_addr  = CNT_W'(i_data_start);
                        n_state = bomap_pkg::S_SCAN;
                    end else begin
                        n_res.blk_idx = '0;
                        n_res.status  = (i_in_data.opcode == bomap_pkg::OP_RELEASE)
                                      ? bomap_pkg::ST_OK : bomap_pkg::ST_FAIL;
                        n_state = bomap_pkg::S_DONE;
                    end
                end
            end

            // one read issued and one entry examined per cycle
            bomap_pkg::S_SCAN: begin
                if (r_addr != ADDR_END) begin
                    o_mem_re   = 1'b1;
                    n_addr     = r_addr + 1'b1;
                    n_rd_valid = 1'b1;
                    n_rd_addr  = r_addr[AW-1:0];
                end else begin
                    n_rd_valid = 1'b0;
                end

                if (r_rd_valid) begin
                    case (r_op)
                        bomap_pkg::OP_ALLOC: begin
                            if (i_mem_rdata == bomap_pkg::FREE_TAG) begin
                                o_mem_we      = 1'b1;
                                o_mem_wdata   = fid_tag;
                                n_res.blk_idx = bomap_pkg::BI_W'(r_rd_addr);
                                n_res.status  = bomap_pkg::ST_OK;
                                n_rd_valid    = 1'b0;
                                n_state       = bomap_pkg::S_DONE;
                            end
                        end
                        bomap_pkg::OP_LOOKUP: begin
                            if (i_mem_rdata == fid_tag) begin
                                if (r_count == r_want) begin
                                    n_res.blk_idx = bomap_pkg::BI_W'(r_rd_addr);
                                    n_res.status  = bomap_pkg::ST_OK;
                                    n_rd_valid    = 1'b0;
                                    n_state       = bomap_pkg::S_DONE;
                                end else begin
                                    n_count = r_count + 1'b1;
                                end
                            end
                        end
                        bomap_pkg::OP_RELEASE: begin
                            if (i_mem_rdata == fid_tag) begin
                                o_mem_we    = 1'b1;
                                o_mem_wdata = bomap_pkg::FREE_TAG;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else if (r_addr == ADDR_END) begin
                    // range exhausted with no read in flight
                    n_res.blk_idx = '0;
                    n_res.status  = (r_op == bomap_pkg::OP_RELEASE)
                                  ? bomap_pkg::ST_OK : bomap_pkg::ST_FAIL;
                    n_state       = bomap_pkg::S_DONE;
                end
            end

            // hand the result to the output register once it is free
            bomap_pkg::S_DONE: begin
                n_rd_valid = 1'b0;
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = bomap_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = bomap_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bomap_pkg::S_CLEAR;
            r_addr      <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
        r_op      <= n_op;
        r_fid     <= n_fid;
        r_want    <= n_want;
        r_count   <= n_count;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire
